// ===== rtl/dtte_pkg.sv =====
// shared types, constants and helper functions for the timestamp-to-epoch block
`default_nettype none

package dtte_pkg;

	// field widths
	localparam int YEAR_W  = 14;
	localparam int FIELD_W = 7;
	localparam int POS_W   = 5;
	localparam int SECS_W  = 39;
	localparam int DAYS_W  = 24;
	localparam int HMS_W   = 17;

	// character positions of interest
	localparam logic [POS_W-1:0] POS_DASH_MON   = 5'd4;
	localparam logic [POS_W-1:0] POS_DASH_DAY   = 5'd7;
	localparam logic [POS_W-1:0] POS_SPACE      = 5'd10;
	localparam logic [POS_W-1:0] POS_COLON_MIN  = 5'd13;
	localparam logic [POS_W-1:0] POS_COLON_SEC  = 5'd16;
	localparam logic [POS_W-1:0] POS_FINAL      = 5'd18;
	localparam logic [POS_W-1:0] POS_OVERRUN    = 5'd19;
	localparam logic [POS_W-1:0] POS_LIMIT      = 5'd20;

	// ascii codes
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// calendar constants
	localparam logic [25:0] DAYS_PER_ERA     = 26'd146097;
	localparam logic [25:0] EPOCH_SHIFT_DAYS = 26'd719468;
	localparam logic [17:0] DAYS_PER_YEAR    = 18'd365;
	localparam logic [14:0] YEARS_PER_ERA    = 15'd400;
	localparam logic [40:0] SEC_PER_DAY      = 41'd86400;
	localparam logic [18:0] SEC_PER_HOUR     = 19'd3600;
	localparam logic [18:0] SEC_PER_MIN      = 19'd60;

	// parsed fields handed from the parser to the epoch pipeline
	typedef struct packed {
		logic               fmt_ok;
		logic               leap;
		logic [YEAR_W-1:0]  year;
		logic [FIELD_W-1:0] month;
		logic [FIELD_W-1:0] day;
		logic [FIELD_W-1:0] hour;
		logic [FIELD_W-1:0] minute;
		logic [FIELD_W-1:0] second;
	} dt_fields_t;

	// acc * 10 + d, wrapped to 7 bits
	function automatic logic [FIELD_W-1:0] add_digit7(input logic [FIELD_W-1:0] acc,
		input logic [3:0] d);
		logic [10:0] sum;
		sum = 11'(acc) * 11'd10 + 11'(d);
		return sum[FIELD_W-1:0];
	endfunction

	// acc * 10 + d, wrapped to 14 bits
	function automatic logic [YEAR_W-1:0] add_digit14(input logic [YEAR_W-1:0] acc,
		input logic [3:0] d);
		logic [17:0] sum;
		sum = 18'(acc) * 18'd10 + 18'(d);
		return sum[YEAR_W-1:0];
	endfunction

	// running remainder of the year mod 25, one decimal digit at a time
	function automatic logic [4:0] mod25_step(input logic [4:0] r, input logic [3:0] d);
		logic [7:0]  x;
		logic [13:0] prod;
		logic [3:0]  q;
		logic [7:0]  rem;
		x    = 8'(r) * 8'd10 + 8'(d);
		prod = 14'(x) * 14'd41;
		q    = prod[13:10];
		rem  = x - 8'(q) * 8'd25;
		return rem[4:0];
	endfunction

	// day of a march-based year on which each month starts
	function automatic logic [8:0] month_start(input logic [FIELD_W-1:0] m);
		logic [8:0] s;
		case (m)
			7'd1:    s = 9'd306;
			7'd2:    s = 9'd337;
			7'd3:    s = 9'd0;
			7'd4:    s = 9'd31;
			7'd5:    s = 9'd61;
			7'd6:    s = 9'd92;
			7'd7:    s = 9'd122;
			7'd8:    s = 9'd153;
			7'd9:    s = 9'd184;
			7'd10:   s = 9'd214;
			7'd11:   s = 9'd245;
			7'd12:   s = 9'd275;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

	// days in a month, zero for a month number out of range
	function automatic logic [4:0] month_days(input logic [FIELD_W-1:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
			7'd4, 7'd6, 7'd9, 7'd11:                    n = 5'd30;
			7'd2:                                        n = leap ? 5'd29 : 5'd28;
			default:                                     n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dtte_parser.sv =====
// character parser: input register, position tracking and digit accumulators
`default_nettype none

module dtte_parser
	import dtte_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] char_code
	input  wire logic       s_axis_tlast,   // last_char
	output logic            fld_valid,
	input  wire logic       fld_ready,
	output dt_fields_t      fld
);

	logic               valid_s1;
	logic [7:0]         char_s1;
	logic               last_s1;

	logic [POS_W-1:0]   pos_q;
	logic               fmt_ok_q;
	logic [YEAR_W-1:0]  year_q;
	logic [4:0]         year_m25_q;
	logic [FIELD_W-1:0] month_q, day_q, hour_q, minute_q, second_q;

	logic [POS_W-1:0]   pos_n;
	logic               fmt_ok_n;
	logic [YEAR_W-1:0]  year_n;
	logic [4:0]         year_m25_n;
	logic [FIELD_W-1:0] month_n, day_n, hour_n, minute_n, second_n;

	logic [7:0]         digit8;
	logic [3:0]         digit;
	logic               is_digit;
	logic               can_s2;
	logic               consume;
	logic               valid_s2;
	dt_fields_t         fld_s2;

	// handshake between input register, parser and output stage
	assign can_s2        = !valid_s2 || fld_ready;
	assign consume       = valid_s1 && (!last_s1 || can_s2);
	assign s_axis_tready = !valid_s1 || consume;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// next state for one character
	assign digit8   = char_s1 - CH_ZERO;
	assign digit    = digit8[3:0];
	assign is_digit = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);

	always_comb begin
		fmt_ok_n   = fmt_ok_q;
		year_n     = year_q;
		year_m25_n = year_m25_q;
		month_n    = month_q;
		day_n      = day_q;
		hour_n     = hour_q;
		minute_n   = minute_q;
		second_n   = second_q;
		if (pos_q >= POS_OVERRUN) begin
			fmt_ok_n = 1'b0;
		end else if (pos_q == POS_DASH_MON || pos_q == POS_DASH_DAY) begin
			if (char_s1 != CH_DASH) fmt_ok_n = 1'b0;
		end else if (pos_q == POS_SPACE) begin
			if (char_s1 != CH_SPACE) fmt_ok_n = 1'b0;
		end else if (pos_q == POS_COLON_MIN || pos_q == POS_COLON_SEC) begin
			if (char_s1 != CH_COLON) fmt_ok_n = 1'b0;
		end else if (!is_digit) begin
			fmt_ok_n = 1'b0;
		end else if (pos_q < POS_DASH_MON) begin
			year_n     = add_digit14(year_q, digit);
			year_m25_n = mod25_step(year_m25_q, digit);
		end else if (pos_q < POS_DASH_DAY) begin
			month_n = add_digit7(month_q, digit);
		end else if (pos_q < POS_SPACE) begin
			day_n = add_digit7(day_q, digit);
		end else if (pos_q < POS_COLON_MIN) begin
			hour_n = add_digit7(hour_q, digit);
		end else if (pos_q < POS_COLON_SEC) begin
			minute_n = add_digit7(minute_q, digit);
		end else begin
			second_n = add_digit7(second_q, digit);
		end
		pos_n = (pos_q >= POS_LIMIT) ? POS_LIMIT : pos_q + 5'd1;
	end

	// parser state, back to its start after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			fmt_ok_q   <= 1'b1;
			year_q     <= '0;
			year_m25_q <= '0;
			month_q    <= '0;
			day_q      <= '0;
			hour_q     <= '0;
			minute_q   <= '0;
			second_q   <= '0;
		end else if (consume) begin
			if (last_s1) begin
				pos_q      <= '0;
				fmt_ok_q   <= 1'b1;
				year_q     <= '0;
				year_m25_q <= '0;
				month_q    <= '0;
				day_q      <= '0;
				hour_q     <= '0;
				minute_q   <= '0;
				second_q   <= '0;
			end else begin
				pos_q      <= pos_n;
				fmt_ok_q   <= fmt_ok_n;
				year_q     <= year_n;
				year_m25_q <= year_m25_n;
				month_q    <= month_n;
				day_q      <= day_n;
				hour_q     <= hour_n;
				minute_q   <= minute_n;
				second_q   <= second_n;
			end
		end
	end

	// completed fields register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_s2) begin
			valid_s2 <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (can_s2 && valid_s1 && last_s1) begin
			fld_s2.fmt_ok <= fmt_ok_n && (pos_q == POS_FINAL);
			// gregorian leap: divisible by 4, and not by 100 unless by 400
			fld_s2.leap   <= (year_n[1:0] == 2'd0) &&
			                 ((year_m25_n != 5'd0) || (year_n[3:0] == 4'd0));
			fld_s2.year   <= year_n;
			fld_s2.month  <= month_n;
			fld_s2.day    <= day_n;
			fld_s2.hour   <= hour_n;
			fld_s2.minute <= minute_n;
			fld_s2.second <= second_n;
		end
	end

	assign fld_valid = valid_s2;
	assign fld       = fld_s2;

endmodule

`default_nettype wire

// ===== rtl/dtte_epoch.sv =====
// epoch pipeline: range check, days-from-civil and seconds, with output register
`default_nettype none

module dtte_epoch
	import dtte_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fld_valid,
	output logic             fld_ready,
	input  dt_fields_t       fld,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // [38:0] unix_seconds, [39] zero fill
	output logic             m_axis_tuser   // valid_res
);

	logic valid_s3, valid_s4, valid_s5, valid_s6;
	logic can_s3, can_s4, can_s5, can_s6;

	// stage 3 signals
	logic [4:0]         mdays;
	logic               in_range;
	logic [YEAR_W-1:0]  y_adj;
	logic [20:0]        era_prod;
	logic [8:0]         doy;
	logic [18:0]        hms_full;
	logic               ok_s3;
	logic [YEAR_W-1:0]  y_s3;
	logic [5:0]         era0_s3;
	logic [8:0]         doy_s3;
	logic [HMS_W-1:0]   hms_s3;

	// stage 4 signals
	logic [14:0]        rem_full;
	logic [9:0]         rem;
	logic               ok_s4;
	logic [5:0]         era_s4;
	logic [8:0]         yoe_s4;
	logic [8:0]         doy_s4;
	logic [HMS_W-1:0]   hms_s4;

	// stage 5 signals
	logic [1:0]         cent;
	logic [17:0]        doe;
	logic [25:0]        days_full;
	logic               ok_s5;
	logic [DAYS_W-1:0]  days_s5;
	logic [HMS_W-1:0]   hms_s5;

	// stage 6 signals
	logic [40:0]        days_ext;
	logic [40:0]        secs_full;
	logic               ok_s6;
	logic [SECS_W-1:0]  secs_s6;

	// a stage loads when it is empty or its content moves on
	assign can_s6    = !valid_s6 || m_axis_tready;
	assign can_s5    = !valid_s5 || can_s6;
	assign can_s4    = !valid_s4 || can_s5;
	assign can_s3    = !valid_s4 || can_s4 ? (!valid_s3 || can_s4) : !valid_s3;
	assign fld_ready = can_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (can_s3) valid_s3 <= fld_valid;
			if (can_s4) valid_s4 <= valid_s3;
			if (can_s5) valid_s5 <= valid_s4;
			if (can_s6) valid_s6 <= valid_s5;
		end
	end

	// range check, shifted year, era estimate, day of year, time of day
	assign mdays    = month_days(fld.month, fld.leap);
	assign in_range = fld.fmt_ok && (fld.year != '0) && (mdays != 5'd0) &&
	                  (fld.day != '0) && (fld.day <= 7'(mdays)) &&
	                  (fld.hour <= 7'd23) && (fld.minute <= 7'd59) &&
	                  (fld.second <= 7'd59);
	assign y_adj    = (fld.month <= 7'd2) ? fld.year - 14'd1 : fld.year;
	// y / 400 as (y / 16) / 25 through a reciprocal, corrected in the next stage
	assign era_prod = 21'(y_adj[YEAR_W-1:4]) * 21'd1311;
	assign doy      = month_start(fld.month) + 9'(fld.day) - 9'd1;
	assign hms_full = 19'(fld.hour) * SEC_PER_HOUR + 19'(fld.minute) * SEC_PER_MIN +
	                  19'(fld.second);

	always_ff @(posedge clk) begin
		if (can_s3 && fld_valid) begin
			ok_s3   <= in_range;
			y_s3    <= y_adj;
			era0_s3 <= era_prod[20:15];
			doy_s3  <= doy;
			hms_s3  <= hms_full[HMS_W-1:0];
		end
	end

	// year of era, with one correction step on the era estimate
	assign rem_full = 15'(y_s3) - 15'(era0_s3) * YEARS_PER_ERA;
	assign rem      = rem_full[9:0];

	always_ff @(posedge clk) begin
		if (can_s4 && valid_s3) begin
			ok_s4  <= ok_s3;
			doy_s4 <= doy_s3;
			hms_s4 <= hms_s3;
			if (rem >= 10'(YEARS_PER_ERA)) begin
				era_s4 <= era0_s3 + 6'd1;
				yoe_s4 <= 9'(rem - 10'(YEARS_PER_ERA));
			end else begin
				era_s4 <= era0_s3;
				yoe_s4 <= rem[8:0];
			end
		end
	end

	// day of era and days since the epoch
	always_comb begin
		if (yoe_s4 >= 9'd300)      cent = 2'd3;
		else if (yoe_s4 >= 9'd200) cent = 2'd2;
		else if (yoe_s4 >= 9'd100) cent = 2'd1;
		else                       cent = 2'd0;
	end
	assign doe       = 18'(yoe_s4) * DAYS_PER_YEAR + 18'(yoe_s4[8:2]) - 18'(cent) +
	                   18'(doy_s4);
	assign days_full = 26'(era_s4) * DAYS_PER_ERA + 26'(doe) - EPOCH_SHIFT_DAYS;

	always_ff @(posedge clk) begin
		if (can_s5 && valid_s4) begin
			ok_s5   <= ok_s4;
			days_s5 <= days_full[DAYS_W-1:0];
			hms_s5  <= hms_s4;
		end
	end

	// seconds since the epoch into the output register
	assign days_ext  = {{(41 - DAYS_W){days_s5[DAYS_W-1]}}, days_s5};
	assign secs_full = days_ext * SEC_PER_DAY + 41'(hms_s5);

	always_ff @(posedge clk) begin
		if (can_s6 && valid_s5) begin
			ok_s6   <= ok_s5;
			secs_s6 <= ok_s5 ? secs_full[SECS_W-1:0] : '0;
		end
	end

	assign m_axis_tvalid = valid_s6;
	assign m_axis_tdata  = {1'b0, secs_s6};
	assign m_axis_tuser  = ok_s6;

endmodule

`default_nettype wire

// ===== rtl/datetime_text_to_epoch_seconds_top.sv =====
// top level: "YYYY-mm-dd HH:MM:SS" character stream to unix seconds
`default_nettype none

// Takes one ASCII character per cycle on the slave stream, tlast on the final
// character of each string, and gives one transaction per string on the master
// stream: tuser high with the seconds since 1970-01-01 UTC when the text is a
// well-formed, in-range date and time of exactly 19 characters, otherwise tuser
// low with zero seconds. Characters are taken every cycle unless a last character
// waits; the result reaches the output register through a six-register pipeline
// (input register, field register, range and era estimate, era correction,
// days-from-civil, seconds). A waiting result does not hold up later characters;
// only a further last character waits, when the output register is held and
// every stage behind it is occupied.
module datetime_text_to_epoch_seconds_top
	import dtte_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  wire logic        s_axis_tlast,   // last_char
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [38:0] unix_seconds, [39] zero fill
	output logic             m_axis_tuser    // valid_res
);

	logic       fld_valid;
	logic       fld_ready;
	dt_fields_t fld;

	// character parser
	dtte_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.fld_valid     (fld_valid),
		.fld_ready     (fld_ready),
		.fld           (fld)
	);

	// epoch arithmetic and output register
	dtte_epoch u_epoch (
		.clk           (clk),
		.arst_n        (arst_n),
		.fld_valid     (fld_valid),
		.fld_ready     (fld_ready),
		.fld           (fld),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// an invalid result carries zero seconds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 40'd0)
		else $error("invalid result with nonzero seconds");

	// a valid result lies between years 1 and 9999
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			$signed(m_axis_tdata[38:0]) >= -39'sd62135596800 &&
			$signed(m_axis_tdata[38:0]) <= 39'sd253402300799)
		else $error("valid result outside calendar range");

	// with the output register empty the epoch pipeline always takes fields
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> fld_ready)
		else $error("epoch pipeline stalled with empty output");

endmodule

`default_nettype wire
